[sv/cas_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the contrast adaptive sharpening block.
package cas_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int CSR_W = 12;
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0] RST_WIDTH  = 12'd1920;
   localparam logic [CSR_W-1:0] RST_HEIGHT = 12'd1080;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   // one queued request: the five-pixel cross and the line/frame flags
   typedef struct packed {
      logic [23:0] above;
      logic [23:0] left;
      logic [23:0] centre;
      logic [23:0] right;
      logic [23:0] below;
      logic        eol;
      logic        eof;
   } cross_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_READ,
      FR_RIGHT,
      FR_WRITE
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_QDIV,
      BK_SQRT,
      BK_WEIGHT,
      BK_NUM,
      BK_RDIV,
      BK_NEXT
   } back_state_type;

endpackage

[sv/contrast_adaptive_sharpen_rgb8.sv]
`timescale 1ns / 1ps
// Top level of the contrast adaptive sharpening filter for 8-bit RGB video.
//
// Pixels enter in raster order on the req_ channel (operation 0); each result is
// the sharpened pixel one row above, using the cross above/left/centre/right/below
// with missing neighbors replaced by the centre. Row 0 gives no results. After the
// last pixel of a frame, one drain request (operation 1) per pixel flushes the last
// row; the last drained pixel carries end_of_frame. Pixels sent while draining and
// drains sent otherwise are dropped. Writing image_width or image_height restarts
// the frame; write them only while the block is idle. The front end handles a request
// in turn as a line store read, a right-neighbor read and a write back; the back end
// works per channel (16-step ratio divide, 17-step square root, weight multiply,
// 11-step normalizing divide), three channels in turn, and takes a new request only
// when it is through with the last one, so the back end sets the sustained rate. A
// two-entry queue lets the front end take requests while the back end works and
// while a result waits on rsp_ready. No clearing pass is run after reset.
module contrast_adaptive_sharpen_rgb8 #(
   parameter int MAX_WIDTH  = cas_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cas_pkg::DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [cas_pkg::CSR_W-1:0] csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [7:0]                req_in_red,
   input  logic [7:0]                req_in_green,
   input  logic [7:0]                req_in_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_red,
   output logic [7:0]                rsp_out_green,
   output logic [7:0]                rsp_out_blue,
   output logic                      rsp_end_of_line,
   output logic                      rsp_end_of_frame
);

   logic [cas_pkg::CSR_W-1:0] width_ff;
   logic [cas_pkg::CSR_W-1:0] height_ff;

   cas_pkg::q_status_type q_status;
   cas_pkg::cross_type    push_data;
   cas_pkg::cross_type    head;
   logic                  push;
   logic                  pop;

   // geometry registers; any write restarts the frame in the front end
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cas_pkg::RST_WIDTH;
         height_ff <= cas_pkg::RST_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            cas_pkg::CSR_IDX_WIDTH:  width_ff  <= csr_data;
            cas_pkg::CSR_IDX_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   cas_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_we),
      .cfg_width    (width_ff),
      .cfg_height   (height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .q_status     (q_status),
      .push         (push),
      .push_data    (push_data)
   );

   cas_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   cas_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_end_of_line (rsp_end_of_line),
      .rsp_end_of_frame(rsp_end_of_frame)
   );

endmodule

[sv/cas_front.sv]
`timescale 1ns / 1ps
// Front end: request intake, line stores and cross assembly.
module cas_front #(
   parameter int MAX_WIDTH  = cas_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cas_pkg::DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic [cas_pkg::CSR_W-1:0] cfg_width,
   input  logic [cas_pkg::CSR_W-1:0] cfg_height,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [7:0]               req_in_red,
   input  logic [7:0]               req_in_green,
   input  logic [7:0]               req_in_blue,
   input  cas_pkg::q_status_type    q_status,
   output logic                     push,
   output cas_pkg::cross_type       push_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic [23:0] older_mem  [MAX_WIDTH];
   logic [23:0] middle_mem [MAX_WIDTH];

   cas_pkg::front_state_type state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          drain_ff, drain_in;
   logic [23:0]   prev_ff, prev_in;
   logic          op_ff;
   logic [23:0]   pix_ff;
   logic [23:0]   centre_ff;
   logic [23:0]   older_rd_ff;
   logic [23:0]   middle_rd_ff;

   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [CW-1:0] col_plus;
   logic [AW-1:0] maddr;
   logic          accept;
   logic          wrap;
   logic          go;
   logic          first_col;
   logic          last_col;

   always_comb begin
      if (cfg_width == '0) begin
         w_eff = CW'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg_width);
      end
      if (cfg_height == '0) begin
         h_eff = RW'(1);
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(cfg_height);
      end
   end

   assign col_plus  = col_ff + CW'(1);
   assign first_col = (col_ff == '0);
   assign last_col  = (col_plus == w_eff);
   assign maddr     = (state_ff == cas_pkg::FR_RIGHT) ? col_plus[AW-1:0] : col_ff[AW-1:0];

   assign req_ready = (state_ff == cas_pkg::FR_IDLE) && !q_status.full;
   assign accept    = req_valid && req_ready;
   // a frame that ran past the current geometry starts over
   assign wrap      = (col_ff >= w_eff) || (row_ff >= h_eff);
   assign go        = (req_operation == cas_pkg::OP_PIXEL) ? !(drain_ff && !wrap)
                                                           : (drain_ff && !wrap);

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      prev_in  = prev_ff;
      push     = 1'b0;
      push_data.centre = centre_ff;
      push_data.left   = first_col ? centre_ff : prev_ff;
      push_data.right  = last_col ? centre_ff : middle_rd_ff;
      push_data.eol    = last_col;
      if (op_ff == cas_pkg::OP_PIXEL) begin
         push_data.above = (row_ff == RW'(1)) ? centre_ff : older_rd_ff;
         push_data.below = pix_ff;
         push_data.eof   = 1'b0;
      end else begin
         push_data.above = (row_ff == '0) ? centre_ff : older_rd_ff;
         push_data.below = centre_ff;
         push_data.eof   = last_col;
      end
      case (state_ff)
         cas_pkg::FR_IDLE: begin
            if (accept) begin
               if (wrap) begin
                  col_in   = '0;
                  row_in   = '0;
                  drain_in = 1'b0;
                  prev_in  = '0;
               end
               state_in = go ? cas_pkg::FR_READ : cas_pkg::FR_IDLE;
            end
         end
         cas_pkg::FR_READ: begin
            state_in = cas_pkg::FR_RIGHT;
         end
         cas_pkg::FR_RIGHT: begin
            state_in = cas_pkg::FR_WRITE;
         end
         cas_pkg::FR_WRITE: begin
            state_in = cas_pkg::FR_IDLE;
            prev_in  = centre_ff;
            push     = (op_ff == cas_pkg::OP_DRAIN) || (row_ff != '0);
            if (op_ff == cas_pkg::OP_PIXEL) begin
               if (last_col) begin
                  col_in = '0;
                  if (row_ff + RW'(1) == h_eff) begin
                     drain_in = 1'b1;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = col_plus;
               end
            end else begin
               if (last_col) begin
                  col_in   = '0;
                  row_in   = '0;
                  drain_in = 1'b0;
                  prev_in  = '0;
               end else begin
                  col_in = col_plus;
               end
            end
         end
         default: begin
            state_in = cas_pkg::FR_IDLE;
         end
      endcase
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = 1'b0;
         prev_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cas_pkg::FR_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         pix_ff <= {req_in_red, req_in_green, req_in_blue};
      end
      if (state_ff == cas_pkg::FR_RIGHT) begin
         centre_ff <= middle_rd_ff;
      end
   end

   // line stores: reads at column and column+1, writes once per pixel
   always_ff @(posedge clock) begin
      if (state_ff == cas_pkg::FR_READ || state_ff == cas_pkg::FR_RIGHT) begin
         middle_rd_ff <= middle_mem[maddr];
      end
      if (state_ff == cas_pkg::FR_READ) begin
         older_rd_ff <= older_mem[col_ff[AW-1:0]];
      end
      if (state_ff == cas_pkg::FR_WRITE && op_ff == cas_pkg::OP_PIXEL) begin
         older_mem[col_ff[AW-1:0]]  <= centre_ff;
         middle_mem[col_ff[AW-1:0]] <= pix_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cas_pkg::FR_IDLE) |-> (col_ff < w_eff))
      else $error("column beyond line width");
`endif

endmodule

[sv/cas_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between the front end and the arithmetic back end.
module cas_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cas_pkg::cross_type    push_data,
   input  logic                  pop,
   output cas_pkg::cross_type    head,
   output cas_pkg::q_status_type status
);

   cas_pkg::cross_type entry_ff [cas_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'(cas_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/cas_back.sv]
`timescale 1ns / 1ps
// Back end: per-channel ratio divide, sqrt, weight and normalizing divide, one channel at a time.
module cas_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cas_pkg::q_status_type q_status,
   input  cas_pkg::cross_type    head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame
);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [13:0] WEIGHT_K = 14'd13107;

   cas_pkg::back_state_type state_ff, state_in;
   cas_pkg::cross_type item_ff;
   logic [1:0]  chan_ff;
   logic [7:0]  mx_ff;
   logic [7:0]  rem_ff;
   logic [16:0] qd_ff;
   logic [4:0]  step_ff;
   logic [7:0]  cen_ff;
   logic [9:0]  sum4_ff;
   logic [32:0] sv_ff;
   logic [33:0] res_ff;
   logic [33:0] bit_ff;
   logic [13:0] wm_ff;
   logic        neg_ff;
   logic [26:0] nd_ff;
   logic [27:0] dsh_ff;
   logic [10:0] qres_ff;
   logic [7:0]  red_hold_ff;
   logic [7:0]  green_hold_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic        rsp_eol_ff, rsp_eof_ff;

   logic [7:0]  ct, cl, cc, cr, cb;
   logic [7:0]  mn, mx, lo_a, hi_a, a_val;
   logic [8:0]  r2;
   logic        qbit;
   logic [33:0] trial;
   logic [30:0] wprod;
   logic [23:0] nprod;
   logic signed [25:0] num;
   logic [16:0] den;
   logic [7:0]  chan_res;
   logic        out_free;
   logic        load_out;

   always_comb begin
      case (chan_ff)
         CH_RED: begin
            ct = item_ff.above[23:16];  cl = item_ff.left[23:16];
            cc = item_ff.centre[23:16]; cr = item_ff.right[23:16];
            cb = item_ff.below[23:16];
         end
         CH_GREEN: begin
            ct = item_ff.above[15:8];  cl = item_ff.left[15:8];
            cc = item_ff.centre[15:8]; cr = item_ff.right[15:8];
            cb = item_ff.below[15:8];
         end
         default: begin
            ct = item_ff.above[7:0];  cl = item_ff.left[7:0];
            cc = item_ff.centre[7:0]; cr = item_ff.right[7:0];
            cb = item_ff.below[7:0];
         end
      endcase
   end

   always_comb begin
      mn = cc;
      mx = cc;
      if (ct < mn) mn = ct;
      if (cl < mn) mn = cl;
      if (cr < mn) mn = cr;
      if (cb < mn) mn = cb;
      if (ct > mx) mx = ct;
      if (cl > mx) mx = cl;
      if (cr > mx) mx = cr;
      if (cb > mx) mx = cb;
      hi_a  = 8'd255 - mx;
      lo_a  = mn;
      a_val = (lo_a < hi_a) ? lo_a : hi_a;
   end

   assign r2    = {rem_ff, 1'b0};
   assign qbit  = (mx_ff != '0) && (r2 >= {1'b0, mx_ff});
   assign trial = res_ff + bit_ff;
   assign wprod = res_ff[16:0] * WEIGHT_K;
   assign nprod = wm_ff * sum4_ff;
   assign num   = $signed({2'b00, cen_ff, 16'd0}) - $signed({2'b00, nprod});
   assign den   = 17'h10000 - {1'b0, wm_ff, 2'b00};
   assign chan_res = neg_ff ? 8'd0 : ((qres_ff > 11'd255) ? 8'd255 : qres_ff[7:0]);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == cas_pkg::BK_IDLE) && !q_status.empty;
   assign load_out = (state_ff == cas_pkg::BK_NEXT) && (chan_ff == CH_BLUE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cas_pkg::BK_IDLE:   if (!q_status.empty) state_in = cas_pkg::BK_PREP;
         cas_pkg::BK_PREP:   state_in = cas_pkg::BK_QDIV;
         cas_pkg::BK_QDIV:   if (step_ff == '0) state_in = cas_pkg::BK_SQRT;
         cas_pkg::BK_SQRT:   if (step_ff == '0) state_in = cas_pkg::BK_WEIGHT;
         cas_pkg::BK_WEIGHT: state_in = cas_pkg::BK_NUM;
         cas_pkg::BK_NUM:    state_in = cas_pkg::BK_RDIV;
         cas_pkg::BK_RDIV:   if (step_ff == '0) state_in = cas_pkg::BK_NEXT;
         cas_pkg::BK_NEXT: begin
            if (chan_ff != CH_BLUE) begin
               state_in = cas_pkg::BK_PREP;
            end else if (out_free) begin
               state_in = cas_pkg::BK_IDLE;
            end
         end
         default: state_in = cas_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cas_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cas_pkg::BK_IDLE: begin
            if (pop) begin
               item_ff <= head;
               chan_ff <= CH_RED;
            end
         end
         cas_pkg::BK_PREP: begin
            // quotient is a*65536/mx with a <= mx: integer part is 0 or 1
            mx_ff   <= mx;
            cen_ff  <= cc;
            sum4_ff <= 10'(ct) + 10'(cl) + 10'(cr) + 10'(cb);
            if ((a_val == mx) && (mx != '0)) begin
               qd_ff  <= 17'h10000;
               rem_ff <= '0;
            end else begin
               qd_ff  <= '0;
               rem_ff <= a_val;
            end
            step_ff <= 5'd15;
         end
         cas_pkg::BK_QDIV: begin
            qd_ff  <= {qd_ff[16], qd_ff[14:0], qbit};
            rem_ff <= qbit ? 8'(r2 - {1'b0, mx_ff}) : r2[7:0];
            if (step_ff == '0) begin
               sv_ff   <= {qd_ff[16], qd_ff[14:0], qbit, 16'd0};
               res_ff  <= '0;
               bit_ff  <= 34'(1) << 32;
               step_ff <= 5'd16;
            end else begin
               step_ff <= step_ff - 5'd1;
            end
         end
         cas_pkg::BK_SQRT: begin
            if ({1'b0, sv_ff} >= trial) begin
               sv_ff  <= 33'({1'b0, sv_ff} - trial);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff - 5'd1;
         end
         cas_pkg::BK_WEIGHT: begin
            wm_ff <= wprod[29:16];
         end
         cas_pkg::BK_NUM: begin
            // divisor is 2*den, first quotient bit at 2^10
            neg_ff  <= (num <= 26'sd0);
            nd_ff   <= 27'({num[25:0], 1'b0}) + 27'(den);
            dsh_ff  <= {den, 11'd0};
            qres_ff <= '0;
            step_ff <= 5'd10;
         end
         cas_pkg::BK_RDIV: begin
            if ({1'b0, nd_ff} >= dsh_ff) begin
               nd_ff   <= 27'({1'b0, nd_ff} - dsh_ff);
               qres_ff <= {qres_ff[9:0], 1'b1};
            end else begin
               qres_ff <= {qres_ff[9:0], 1'b0};
            end
            dsh_ff  <= dsh_ff >> 1;
            if (step_ff != '0) begin
               step_ff <= step_ff - 5'd1;
            end
         end
         cas_pkg::BK_NEXT: begin
            case (chan_ff)
               CH_RED:   begin red_hold_ff   <= chan_res; chan_ff <= CH_GREEN; end
               CH_GREEN: begin green_hold_ff <= chan_res; chan_ff <= CH_BLUE;  end
               default: begin
                  if (load_out) begin
                     rsp_red_ff   <= red_hold_ff;
                     rsp_green_ff <= green_hold_ff;
                     rsp_blue_ff  <= chan_res;
                     rsp_eol_ff   <= item_ff.eol;
                     rsp_eof_ff   <= item_ff.eof;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_red_ff;
   assign rsp_out_green    = rsp_green_ff;
   assign rsp_out_blue     = rsp_blue_ff;
   assign rsp_end_of_line  = rsp_eol_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

`ifndef NO_ASSERTIONS
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cas_pkg::BK_SQRT) |-> (qd_ff <= 17'h10000))
      else $error("ratio above one");
   a_wm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cas_pkg::BK_NUM) |-> (wm_ff <= WEIGHT_K))
      else $error("weight above limit");
`endif

endmodule
